FILE: rtl/core/psrl_pkg.sv
package psrl_pkg;

  // register indexes of the configuration port
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] REG_PACKET_LIMIT = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_WINDOW_TICKS = 8'd1;

  localparam logic [15:0] RESET_PACKET_LIMIT = 16'd1000;
  localparam logic [31:0] RESET_WINDOW_TICKS = 32'd1000000;

  // verdict codes
  localparam logic [1:0] VERDICT_WITHIN    = 2'd0;
  localparam logic [1:0] VERDICT_OVER      = 2'd1;
  localparam logic [1:0] VERDICT_DISABLED  = 2'd2;
  localparam logic [1:0] VERDICT_UNTRACKED = 2'd3;

  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] arrival_time;
  } in_item_t;

  typedef struct packed {
    logic       admit;
    logic [1:0] verdict;
  } out_item_t;

  // one table entry as held in the memory
  typedef struct packed {
    logic [31:0] source;
    logic [31:0] window_begin;
    logic [15:0] tally;
  } entry_t;

endpackage

FILE: rtl/core/per_source_rate_limiter_unit.sv
// channel | direction | handshake                 | payload
// --------+-----------+---------------------------+---------------------------------
// in      | input     | in_valid_i / in_ready_o   | in_data_i  (source, arrival time)
// out     | output    | out_valid_o / out_ready_i | out_data_o (admit, verdict)
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// one transaction at a time: a packet walks the filled entries until its source matches (the whole
// table for a new source, none on an empty table), then decides; with limiting off it skips the walk
// the walk reads one table entry per cycle from the entry memory
// reset clears the fill count, not the entry memory, so the table is empty right away (no clearing pass)
// a result waiting in the output register does not block the next input transaction;
// only the decision step waits for the output register to drain
module per_source_rate_limiter_unit #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  psrl_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output psrl_pkg::out_item_t                out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [psrl_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [psrl_pkg::CfgDataW-1:0]      cfg_data_i
);
  import psrl_pkg::*;

  // table index and fill count widths
  localparam int unsigned AddrW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CountW = $clog2(TABLE_ENTRIES + 1);

  logic [15:0]      packet_limit_q;
  logic [31:0]      window_ticks_q;

  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  entry_t           wr_data;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  entry_t           rd_data;

  // configuration registers, writes to unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      packet_limit_q <= RESET_PACKET_LIMIT;
      window_ticks_q <= RESET_WINDOW_TICKS;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_PACKET_LIMIT: packet_limit_q <= cfg_data_i[15:0];
        REG_WINDOW_TICKS: window_ticks_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // scan, decision and output register
  psrl_ctrl #(
    .Entries (TABLE_ENTRIES),
    .AddrW   (AddrW),
    .CountW  (CountW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .packet_limit_i (packet_limit_q),
    .window_ticks_i (window_ticks_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_data_i      (in_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (out_data_o),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data)
  );

  // source table: source, window start and tally per entry
  psrl_table #(
    .Entries (TABLE_ENTRIES),
    .AddrW   (AddrW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

endmodule

FILE: rtl/core/psrl_table.sv
module psrl_table #(
  parameter int unsigned Entries = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [AddrW-1:0]     wr_addr_i,
  input  psrl_pkg::entry_t     wr_data_i,
  input  logic                 rd_en_i,
  input  logic [AddrW-1:0]     rd_addr_i,
  output psrl_pkg::entry_t     rd_data_o
);
  import psrl_pkg::*;

  entry_t mem [Entries];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/core/psrl_ctrl.sv
module psrl_ctrl #(
  parameter int unsigned Entries = 64,
  parameter int unsigned AddrW = 6,
  parameter int unsigned CountW = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [15:0]           packet_limit_i,
  input  logic [31:0]           window_ticks_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  psrl_pkg::in_item_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output psrl_pkg::out_item_t   out_data_o,
  output logic                  wr_en_o,
  output logic [AddrW-1:0]      wr_addr_o,
  output psrl_pkg::entry_t      wr_data_o,
  output logic                  rd_en_o,
  output logic [AddrW-1:0]      rd_addr_o,
  input  psrl_pkg::entry_t      rd_data_i
);
  import psrl_pkg::*;

  localparam int unsigned NextW = CountW + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_e;

  state_e           state_q;
  logic [31:0]      src_q;
  logic [31:0]      now_q;
  logic             disabled_q;
  logic [AddrW-1:0] addr_q;
  logic             issue_q;
  logic             cmp_vld_q;
  logic [AddrW-1:0] cmp_idx_q;
  logic             hit_q;
  logic [AddrW-1:0] hit_idx_q;
  entry_t           hit_entry_q;
  logic             stale_q;
  logic [AddrW-1:0] stale_idx_q;
  logic [CountW-1:0] fill_q;
  logic             out_valid_q;
  out_item_t        out_data_q;

  logic             accept;
  logic             scan_match;
  logic             scan_stale;
  logic             more_reads;
  logic             fill_avail;
  logic             go;
  logic             hit_elapsed;
  logic [15:0]      hit_tally;
  logic [31:0]      hit_begin;
  logic             hit_over;
  out_item_t        result;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  // sequential walk, one read issued per cycle
  assign rd_en_o    = (state_q == ST_SCAN) && issue_q;
  assign rd_addr_o  = addr_q;
  assign scan_match = cmp_vld_q && (rd_data_i.source == src_q);
  assign scan_stale = cmp_vld_q && ((now_q - rd_data_i.window_begin) >= window_ticks_i);
  assign more_reads = (NextW'(addr_q) + NextW'(1)) < NextW'(fill_q);

  // entries fill from index zero and are never released
  assign fill_avail = fill_q < CountW'(Entries);

  assign hit_elapsed = (now_q - hit_entry_q.window_begin) >= window_ticks_i;
  assign hit_tally   = hit_elapsed ? 16'd0 : hit_entry_q.tally;
  assign hit_begin   = hit_elapsed ? now_q : hit_entry_q.window_begin;
  assign hit_over    = hit_tally >= packet_limit_i;

  assign go = (state_q == ST_DECIDE) && (!out_valid_q || out_ready_i);

  always_comb begin
    result    = '{admit: 1'b1, verdict: VERDICT_WITHIN};
    wr_en_o   = 1'b0;
    wr_addr_o = hit_idx_q;
    wr_data_o = '{source: src_q, window_begin: now_q, tally: 16'd1};
    if (disabled_q) begin
      result.verdict = VERDICT_DISABLED;
    end else if (hit_q) begin
      wr_en_o = go;
      wr_data_o.window_begin = hit_begin;
      if (hit_over) begin
        result = '{admit: 1'b0, verdict: VERDICT_OVER};
        wr_data_o.tally = hit_tally;
      end else begin
        wr_data_o.tally = hit_tally + 16'd1;
      end
    end else if (fill_avail) begin
      wr_en_o   = go;
      wr_addr_o = fill_q[AddrW-1:0];
    end else if (stale_q) begin
      wr_en_o   = go;
      wr_addr_o = stale_idx_q;
    end else begin
      result.verdict = VERDICT_UNTRACKED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      src_q       <= '0;
      now_q       <= '0;
      disabled_q  <= 1'b0;
      addr_q      <= '0;
      issue_q     <= 1'b0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      hit_entry_q <= '0;
      stale_q     <= 1'b0;
      stale_idx_q <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            src_q      <= in_data_i.source_address;
            now_q      <= in_data_i.arrival_time;
            disabled_q <= (packet_limit_i == 16'd0);
            hit_q      <= 1'b0;
            stale_q    <= 1'b0;
            addr_q     <= '0;
            cmp_vld_q  <= 1'b0;
            issue_q    <= (fill_q != '0) && (packet_limit_i != 16'd0);
            state_q    <= (packet_limit_i == 16'd0) ? ST_DECIDE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_match) begin
            hit_q       <= 1'b1;
            hit_idx_q   <= cmp_idx_q;
            hit_entry_q <= rd_data_i;
            cmp_vld_q   <= 1'b0;
            issue_q     <= 1'b0;
            state_q     <= ST_DECIDE;
          end else begin
            if (scan_stale && !stale_q) begin
              stale_q     <= 1'b1;
              stale_idx_q <= cmp_idx_q;
            end
            cmp_vld_q <= issue_q;
            cmp_idx_q <= addr_q;
            if (issue_q) begin
              addr_q  <= addr_q + AddrW'(1);
              issue_q <= more_reads;
            end
            if (!issue_q && !cmp_vld_q) begin
              state_q <= ST_DECIDE;
            end
          end
        end
        ST_DECIDE: begin
          if (go) begin
            out_data_q  <= result;
            if (!disabled_q && !hit_q && fill_avail) begin
              fill_q <= fill_q + CountW'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CountW'(Entries))
    else $error("fill count beyond table size");

  a_wr_only_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (state_q == ST_DECIDE) && !disabled_q)
    else $error("table write outside decision");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> (fill_q == $past(fill_q) + CountW'(1)))
    else $error("fill count moved by more than one");

  a_rd_scan_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_o |-> (NextW'(addr_q) < NextW'(fill_q)))
    else $error("read beyond filled entries");

  a_result_per_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> out_valid_o && (state_q == ST_IDLE))
    else $error("decision produced no result");
`endif

endmodule
